// ----- rtl/psqg_pkg.sv -----
`timescale 1ns / 1ps
package psqg_pkg;

  localparam int unsigned MAX_EDGES  = 65536;
  localparam int unsigned EDGE_LIMIT = (MAX_EDGES - 1) > 65535 ? 65535 : (MAX_EDGES - 1);

  localparam logic [15:0] LINE_WIDTH_RST = 16'd20;

  localparam logic KIND_VERTEX   = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  // reciprocal of 5 for 32-bit operands, shift 34
  localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;

  localparam logic signed [27:0] VTX_MAX = 28'sh7FF_FFFF;
  localparam logic signed [27:0] VTX_MIN = -28'sh800_0000;

  // one classified edge waiting in the queue
  typedef struct packed {
    logic signed [23:0] x1;
    logic signed [23:0] y1;
    logic signed [23:0] x2;
    logic signed [23:0] y2;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic               zero_len;
    logic               last;
    logic [17:0]        base;
  } edge_t;

endpackage

// ----- rtl/psqg_fifo.sv -----
`timescale 1ns / 1ps
module psqg_fifo
  import psqg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  edge_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output edge_t head
);

  edge_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
    else $error("queue pop while empty");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop && !full) |=> not_empty)
    else $error("queue lost an entry");

endmodule

// ----- rtl/psqg_front.sv -----
`timescale 1ns / 1ps
module psqg_front
  import psqg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_start_x,
  input  logic signed [23:0] in_start_y,
  input  logic signed [23:0] in_stop_x,
  input  logic signed [23:0] in_stop_y,
  input  logic               in_last_edge,
  input  logic               q_full,
  output logic               q_push,
  output edge_t              q_data
);

  logic [15:0] edge_index_r;
  logic [15:0] edge_index_nxt;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_data.x1       = in_start_x;
    q_data.y1       = in_start_y;
    q_data.x2       = in_stop_x;
    q_data.y2       = in_stop_y;
    q_data.dx       = 25'(in_stop_x) - 25'(in_start_x);
    q_data.dy       = 25'(in_stop_y) - 25'(in_start_y);
    q_data.zero_len = (in_stop_x == in_start_x) && (in_stop_y == in_start_y);
    q_data.last     = in_last_edge;
    q_data.base     = {edge_index_r, 2'b00};
  end

  always_comb begin
    edge_index_nxt = edge_index_r;
    if (in_last_edge) begin
      edge_index_nxt = '0;
    end else if (edge_index_r < 16'(EDGE_LIMIT)) begin
      edge_index_nxt = edge_index_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_index_r <= '0;
    end else if (q_push) begin
      edge_index_r <= edge_index_nxt;
    end
  end

endmodule

// ----- rtl/psqg_isqrt.sv -----
`timescale 1ns / 1ps
module psqg_isqrt
  import psqg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] n,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [63:0] n_r;
  logic [33:0] rem_t;
  logic [33:0] trial;
  logic        take;
  logic        done_r;

  assign rem_t = {rem_r[31:0], n_r[63:62]};
  assign trial = {root_r, 2'b01};
  assign take  = (rem_t >= trial);
  assign done  = done_r;
  assign root  = root_r;

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= n;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r    <= {n_r[61:0], 2'b00};
      rem_r  <= take ? (rem_t - trial) : rem_t;
      root_r <= {root_r[30:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/psqg_back.sv -----
`timescale 1ns / 1ps
module psqg_back
  import psqg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        line_width,
  input  logic               q_not_empty,
  input  edge_t              q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_item_kind,
  output logic signed [27:0] out_vertex_x,
  output logic signed [27:0] out_vertex_y,
  output logic [17:0]        out_corner_a,
  output logic [17:0]        out_corner_b,
  output logic [17:0]        out_corner_c,
  output logic               out_last_of_run
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_RGO, S_ROOT, S_MUL, S_DIV, S_CORN, S_EMIT
  } state_t;

  state_t             state_r;
  logic [23:0]        adx_r, ady_r;
  logic [48:0]        sq_r;
  logic [31:0]        len_r;
  logic [39:0]        px_r, py_r;
  logic [32:0]        remx_r, remy_r;
  logic [23:0]        lowx_r, lowy_r;
  logic [23:0]        qx_r, qy_r;
  logic [4:0]         cnt_r;
  logic signed [24:0] offx_r, offy_r;
  logic [31:0]        t_r;
  logic               neg_r;
  logic signed [27:0] xs_r [4];
  logic signed [27:0] ys_r [4];
  logic [2:0]         beat_r;

  logic               root_done;
  logic [31:0]        root_val;
  logic [55:0]        numx, numy;
  logic [32:0]        dvs;
  logic [33:0]        remx_t, remy_t;
  logic               takex, takey;
  logic signed [24:0] sel_off;
  logic signed [23:0] sel_p;
  logic signed [33:0] v;
  logic [33:0]        vmag;
  logic [33:0]        vr;
  logic [63:0]        prod;
  logic [29:0]        qmag;
  logic signed [27:0] cval;
  logic [17:0]        b;
  logic               emit_go;

  psqg_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_RGO),
    .n     ({1'b0, sq_r, 14'b0}),
    .done  (root_done),
    .root  (root_val)
  );

  // rounded quotient: floor((2N + len) / (2 len)), N = |d| * w * 2^14
  assign numx   = {1'b0, px_r, 15'b0} + {24'b0, len_r};
  assign numy   = {1'b0, py_r, 15'b0} + {24'b0, len_r};
  assign dvs    = {len_r, 1'b0};
  assign remx_t = {remx_r, lowx_r[23]};
  assign remy_t = {remy_r, lowy_r[23]};
  assign takex  = (remx_t >= {1'b0, dvs});
  assign takey  = (remy_t >= {1'b0, dvs});

  // corner order: x1-n, y1-n, x1+n, y1+n, x2+n, y2+n, x2-n, y2-n
  always_comb begin
    sel_off = cnt_r[0] ? offy_r : offx_r;
    case (cnt_r[2:0])
      3'd0, 3'd2: sel_p = q_head.x1;
      3'd1, 3'd3: sel_p = q_head.y1;
      3'd4, 3'd6: sel_p = q_head.x2;
      default:    sel_p = q_head.y2;
    endcase
    if (cnt_r[2:0] == 3'd0 || cnt_r[2:0] == 3'd1 || cnt_r[2:0] == 3'd6 ||
        cnt_r[2:0] == 3'd7) begin
      v = {{2{sel_p[23]}}, sel_p, 8'b0} - 34'(sel_off);
    end else begin
      v = {{2{sel_p[23]}}, sel_p, 8'b0} + 34'(sel_off);
    end
    vmag = v[33] ? 34'(-v) : 34'(v);
    vr   = vmag + 34'd10;
  end

  // rdiv by 20: floor((|v|+10)/4) / 5 via reciprocal
  assign prod = 64'(t_r) * 64'(RECIP5);
  assign qmag = prod[63:34];

  always_comb begin
    if (!neg_r) begin
      cval = (qmag > 30'(VTX_MAX)) ? VTX_MAX : 28'(qmag);
    end else begin
      cval = (qmag > 30'd134217728) ? VTX_MIN : 28'(-qmag);
    end
  end

  assign b       = q_head.base;
  assign emit_go = (state_r == S_EMIT) && (!out_valid || out_ready);
  assign q_pop   = emit_go && (beat_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      beat_r    <= '0;
      cnt_r     <= '0;
    end else begin
      if (emit_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_not_empty) begin
            adx_r  <= q_head.dx[24] ? 24'(-q_head.dx) : 24'(q_head.dx);
            ady_r  <= q_head.dy[24] ? 24'(-q_head.dy) : 24'(q_head.dy);
            offx_r <= '0;
            offy_r <= '0;
            cnt_r  <= '0;
            state_r <= q_head.zero_len ? S_CORN : S_SQ;
          end
        end
        S_SQ: begin
          sq_r    <= 49'(48'(adx_r) * 48'(adx_r)) + 49'(48'(ady_r) * 48'(ady_r));
          state_r <= S_RGO;
        end
        S_RGO: state_r <= S_ROOT;
        S_ROOT: begin
          if (root_done) begin
            len_r   <= root_val;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          px_r    <= 40'(ady_r) * 40'(line_width);
          py_r    <= 40'(adx_r) * 40'(line_width);
          state_r <= S_DIV;
          cnt_r   <= '0;
        end
        S_DIV: begin
          if (cnt_r == 5'd0) begin
            remx_r <= {1'b0, numx[55:24]};
            remy_r <= {1'b0, numy[55:24]};
            lowx_r <= numx[23:0];
            lowy_r <= numy[23:0];
            qx_r   <= '0;
            qy_r   <= '0;
            cnt_r  <= 5'd1;
          end else begin
            remx_r <= takex ? 33'(remx_t - {1'b0, dvs}) : remx_t[32:0];
            remy_r <= takey ? 33'(remy_t - {1'b0, dvs}) : remy_t[32:0];
            lowx_r <= {lowx_r[22:0], 1'b0};
            lowy_r <= {lowy_r[22:0], 1'b0};
            qx_r   <= {qx_r[22:0], takex};
            qy_r   <= {qy_r[22:0], takey};
            if (cnt_r == 5'd24) begin
              cnt_r   <= '0;
              state_r <= S_CORN;
            end else begin
              cnt_r <= cnt_r + 5'd1;
            end
          end
        end
        S_CORN: begin
          if (cnt_r == 5'd0 && offx_r == '0 && offy_r == '0 && !q_head.zero_len &&
              qx_r != '0) begin
            // first pass after division: apply signs of the normal (-dy, dx)
            offx_r <= q_head.dy[24] ? 25'(qx_r) : 25'(-$signed({1'b0, qx_r}));
            offy_r <= q_head.dx[24] ? 25'(-$signed({1'b0, qy_r})) : 25'(qy_r);
            qx_r   <= '0;
          end else if (cnt_r == 5'd0 && !q_head.zero_len && qy_r != '0 &&
                       offx_r == '0 && offy_r == '0) begin
            offy_r <= q_head.dx[24] ? 25'(-$signed({1'b0, qy_r})) : 25'(qy_r);
            qy_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 5'd1;
            if (cnt_r < 5'd8) begin
              t_r   <= vr[33:2];
              neg_r <= v[33];
            end
            if (cnt_r != 5'd0) begin
              if (cnt_r[0]) xs_r[cnt_r[2:1]] <= cval;
              else          ys_r[2'(cnt_r[3:1] - 3'd1)] <= cval;
            end
            if (cnt_r == 5'd8) begin
              beat_r  <= '0;
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            beat_r          <= beat_r + 3'd1;
            out_last_of_run <= (beat_r == 3'd7);
            if (!beat_r[2]) begin
              out_item_kind <= KIND_VERTEX;
              out_vertex_x  <= xs_r[beat_r[1:0]];
              out_vertex_y  <= ys_r[beat_r[1:0]];
              out_corner_a  <= '0;
              out_corner_b  <= '0;
              out_corner_c  <= '0;
            end else begin
              out_item_kind <= KIND_TRIANGLE;
              out_vertex_x  <= '0;
              out_vertex_y  <= '0;
              case (beat_r[1:0])
                2'd0: begin
                  out_corner_a <= b;
                  out_corner_b <= b + 18'd3;
                  out_corner_c <= b + 18'd1;
                end
                2'd1: begin
                  out_corner_a <= b + 18'd1;
                  out_corner_b <= b + 18'd3;
                  out_corner_c <= b + 18'd2;
                end
                2'd2: begin
                  out_corner_a <= b + 18'd3;
                  out_corner_b <= q_head.last ? 18'd0 : b + 18'd4;
                  out_corner_c <= b + 18'd2;
                end
                default: begin
                  out_corner_a <= b + 18'd2;
                  out_corner_b <= b + 18'd3;
                  out_corner_c <= q_head.last ? 18'd1 : b + 18'd5;
                end
              endcase
            end
            if (beat_r == 3'd7) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_tri_no_xy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item_kind == KIND_TRIANGLE) |-> (out_vertex_x == '0 && out_vertex_y == '0))
    else $error("triangle beat carries coordinates");
  a_vtx_no_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item_kind == KIND_VERTEX) |-> (out_corner_a == '0 && out_corner_c == '0))
    else $error("vertex beat carries indices");
  a_last_tri: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |-> out_item_kind == KIND_TRIANGLE)
    else $error("run ends on a vertex");
  a_pop_emit: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && out_last_of_run))
    else $error("edge retired without its final beat");

endmodule

// ----- rtl/polyline_stroke_quad_generator.sv -----
`timescale 1ns / 1ps
// Polyline stroke quad generator.
// Input channel (in_valid/in_ready): one polyline edge per beat, start and
// stop in twips plus a last-edge flag. The front stage takes the beat
// straight into a two-entry queue, classifying it (deltas, zero length,
// vertex base from the edge counter); it stalls only when the queue is full.
// Output channel (out_valid/out_ready): eight beats per edge, four quad
// corners in pixels (8 fraction bits) then four triangles; out_last_of_run
// marks the eighth beat.
// From input accept to the first result the back stage goes through
// pickup and squaring, root start, the 32-step square root, the width
// product, the 24-step rounded division, signs and the divide-by-20 corner
// pass, and the output register; then the 8 beats, one per cycle while the
// receiver does not stall. A zero-length edge skips root and division.
// The back stage sends an edge's last beat before it picks up the next edge.
// cfg_wr_en/cfg_wr_data load line_width (twips); write only while idle.
// Reset (rst_n low, synchronous): line_width = 20, edge counter 0, queue
// empty, no result pending.
// Receiver stall: the output register holds its beat; the back stage waits,
// and the front keeps taking edges until the queue fills.
module polyline_stroke_quad_generator
  import psqg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_start_x,
  input  logic signed [23:0] in_start_y,
  input  logic signed [23:0] in_stop_x,
  input  logic signed [23:0] in_stop_y,
  input  logic               in_last_edge,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_item_kind,
  output logic signed [27:0] out_vertex_x,
  output logic signed [27:0] out_vertex_y,
  output logic [17:0]        out_corner_a,
  output logic [17:0]        out_corner_b,
  output logic [17:0]        out_corner_c,
  output logic               out_last_of_run
);

  logic [15:0] line_width_r;
  logic        q_push, q_pop, q_full, q_not_empty;
  edge_t       q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
    end else if (cfg_wr_en) begin
      line_width_r <= cfg_wr_data;
    end
  end

  psqg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_stop_x    (in_stop_x),
    .in_stop_y    (in_stop_y),
    .in_last_edge (in_last_edge),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  psqg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  psqg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .line_width      (line_width_r),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item_kind   (out_item_kind),
    .out_vertex_x    (out_vertex_x),
    .out_vertex_y    (out_vertex_y),
    .out_corner_a    (out_corner_a),
    .out_corner_b    (out_corner_b),
    .out_corner_c    (out_corner_c),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ----- verif/polyline_stroke_quad_checker.sv -----
`timescale 1ns / 1ps
module polyline_stroke_quad_checker
  import psqg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [23:0] in_start_x,
  input  logic signed [23:0] in_start_y,
  input  logic signed [23:0] in_stop_x,
  input  logic signed [23:0] in_stop_y,
  input  logic               in_last_edge,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_item_kind,
  input  logic signed [27:0] out_vertex_x,
  input  logic signed [27:0] out_vertex_y,
  input  logic [17:0]        out_corner_a,
  input  logic [17:0]        out_corner_b,
  input  logic [17:0]        out_corner_c,
  input  logic               out_last_of_run,
  output int                 mismatches,
  output int                 pending,
  output int                 beats_seen,
  output int                 edges_seen
);

  typedef struct packed {
    logic               kind;
    logic signed [27:0] vx;
    logic signed [27:0] vy;
    logic [17:0]        ca;
    logic [17:0]        cb;
    logic [17:0]        cc;
    logic               last;
  } quad_beat_t;

  quad_beat_t  stroke_q[$];
  logic [15:0] width_mdl;
  logic [15:0] edge_cnt;

  // integer square root, floor
  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // round half away from zero
  function automatic longint div_round(longint n, longint unsigned d);
    longint unsigned m, q;
    m = (n < 0) ? longint'(-n) : n;
    q = (2 * m + d) / (2 * d);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint normal_q8(longint d, longint unsigned len7);
    longint unsigned mag;
    longint q;
    if (len7 == 0) return 0;
    mag = (d < 0) ? longint'(-d) : d;
    q = div_round(longint'((mag * width_mdl) << 14), len7);
    return (d < 0) ? -q : q;
  endfunction

  function automatic logic signed [27:0] to_pixel(longint p, longint off);
    longint v;
    v = div_round(p * 256 + off, 20);
    if (v > 134217727) v = 134217727;
    if (v < -134217728) v = -134217728;
    return v[27:0];
  endfunction

  function automatic quad_beat_t tri_beat(logic [17:0] a, b, c, logic l);
    quad_beat_t t;
    t = '0;
    t.kind = KIND_TRIANGLE;
    t.ca = a; t.cb = b; t.cc = c; t.last = l;
    return t;
  endfunction

  // append one expected beat at the tail
  task automatic add_beat(quad_beat_t bt);
    stroke_q.insert(stroke_q.size(), bt);
  endtask

  task automatic predict_edge();
    longint x1, y1, x2, y2, dx, dy, nx, ny;
    longint unsigned len7;
    logic [17:0] b;
    quad_beat_t v;
    x1 = in_start_x; y1 = in_start_y; x2 = in_stop_x; y2 = in_stop_y;
    dx = x2 - x1; dy = y2 - y1;
    len7 = sqrt_floor(longint'(dx * dx + dy * dy) << 14);
    nx = normal_q8(-dy, len7);
    ny = normal_q8(dx, len7);
    b = 18'(edge_cnt * 4);
    v = '0;
    v.kind = KIND_VERTEX;
    v.vx = to_pixel(x1, -nx); v.vy = to_pixel(y1, -ny); add_beat(v);
    v.vx = to_pixel(x1, nx);  v.vy = to_pixel(y1, ny);  add_beat(v);
    v.vx = to_pixel(x2, nx);  v.vy = to_pixel(y2, ny);  add_beat(v);
    v.vx = to_pixel(x2, -nx); v.vy = to_pixel(y2, -ny); add_beat(v);
    add_beat(tri_beat(b, b + 18'd3, b + 18'd1, 1'b0));
    add_beat(tri_beat(b + 18'd1, b + 18'd3, b + 18'd2, 1'b0));
    if (in_last_edge) begin
      add_beat(tri_beat(b + 18'd3, 18'd0, b + 18'd2, 1'b0));
      add_beat(tri_beat(b + 18'd2, b + 18'd3, 18'd1, 1'b1));
      edge_cnt = 0;
    end else begin
      add_beat(tri_beat(b + 18'd3, b + 18'd4, b + 18'd2, 1'b0));
      add_beat(tri_beat(b + 18'd2, b + 18'd3, b + 18'd5, 1'b1));
      if (edge_cnt < EDGE_LIMIT) edge_cnt++;
    end
  endtask

  always @(posedge clk) begin
    quad_beat_t got, exp_b;
    if (!rst_n) begin
      width_mdl = LINE_WIDTH_RST;
      edge_cnt = 0;
      stroke_q.delete();
      mismatches = 0;
      beats_seen = 0;
      edges_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_item_kind, out_vertex_x, out_vertex_y, out_corner_a,
                out_corner_b, out_corner_c, out_last_of_run};
        beats_seen++;
        if (stroke_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %p", got);
        end else begin
          exp_b = stroke_q.pop_front();
          if (got !== exp_b) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d mismatch: expected %p got %p", beats_seen, exp_b, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_edge();
        edges_seen++;
      end
      if (cfg_wr_en) width_mdl = cfg_wr_data;
    end
    pending = stroke_q.size();
  end

endmodule

// ----- verif/polyline_stroke_quad_generator_tb.sv -----
`timescale 1ns / 1ps
module polyline_stroke_quad_generator_tb;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [15:0]        cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [23:0] in_start_x, in_start_y, in_stop_x, in_stop_y;
  logic               in_last_edge;
  logic               out_valid;
  logic               out_ready;
  logic               out_item_kind;
  logic signed [27:0] out_vertex_x, out_vertex_y;
  logic [17:0]        out_corner_a, out_corner_b, out_corner_c;
  logic               out_last_of_run;

  int mismatches, pending, beats_seen, edges_seen;
  int idle_cycles;
  bit calm_out;        // no receiver stalls in this stretch
  bit calm_in;         // no sender gaps in this stretch
  bit hold_off_req;    // stimulus asks the receiver for a long stall
  bit hold_off_done;

  localparam int STALL_LIMIT = 20000;  // cycles without any beat
  localparam int DRAIN_WAIT  = 200;    // margin after the last expected beat

  polyline_stroke_quad_generator DUT (.*);

  polyline_stroke_quad_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: ~8% random stalls, calm stretch, one long hold-off on request
  initial begin
    int hold;
    out_ready = 1'b0;
    hold_off_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_ready <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
        hold_off_done = 1'b1;
      end
      out_ready <= calm_out || ($urandom_range(99) >= 8);
    end
  end

  // watchdog on accepted beats of any kind
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // one edge beat; random gap before it unless calm
  task automatic send_edge(logic signed [23:0] x1, y1, x2, y2, logic lst);
    while (!calm_in && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_start_x   <= x1;
    in_start_y   <= y1;
    in_stop_x    <= x2;
    in_stop_y    <= y2;
    in_last_edge <= lst;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending, wait until the checker expects no more beats, then a DRAIN_WAIT margin
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_width(logic [15:0] w);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [23:0] rnd_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(2000)) - 24'sd1000;
      2: return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
      default: return 24'($urandom_range(200000)) - 24'sd100000;
    endcase
  endfunction

  // closed path of n segments with random corners
  task automatic send_path(int n);
    logic signed [23:0] px, py, fx, fy, nx2, ny2;
    int k;
    fx = rnd_coord(); fy = rnd_coord();
    px = fx; py = fy;
    for (k = 0; k < n; k++) begin
      if (k == n - 1) begin
        nx2 = fx; ny2 = fy;
      end else if ($urandom_range(15) == 0) begin
        nx2 = px; ny2 = py;   // degenerate edge
      end else begin
        nx2 = rnd_coord(); ny2 = rnd_coord();
      end
      send_edge(px, py, nx2, ny2, k == n - 1);
      px = nx2; py = ny2;
    end
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_start_x = '0; in_start_y = '0; in_stop_x = '0; in_stop_y = '0;
    in_last_edge = 1'b0;
    calm_out = 1'b0;
    calm_in = 1'b0;
    hold_off_req = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset width, axis edges, extremes, zero length, closing edge
    send_edge(24'sd0, 24'sd0, 24'sd200, 24'sd0, 1'b0);
    send_edge(24'sd200, 24'sd0, 24'sd200, 24'sd200, 1'b0);
    send_edge(24'sd200, 24'sd200, 24'sd200, 24'sd200, 1'b0);
    send_edge(24'sd200, 24'sd200, 24'sd0, 24'sd0, 1'b1);
    send_edge(-24'sh800000, -24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
    send_edge(24'sh7FFFFF, -24'sh800000, -24'sh800000, 24'sh7FFFFF, 1'b0);
    send_edge(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
    set_width(16'hFFFF);
    send_edge(-24'sh800000, 24'sd0, 24'sh7FFFFF, 24'sd0, 1'b0);
    send_edge(24'sd0, -24'sh800000, 24'sd0, 24'sh7FFFFF, 1'b0);
    send_edge(-24'sd1, -24'sd1, 24'sd1, 24'sd0, 1'b0);
    send_edge(24'sh555555, -24'sh2AAAAB, -24'sh2AAAAB, 24'sh555555, 1'b1);
    set_width(16'd0);
    send_edge(-24'sd37, 24'sd91, 24'sd500, -24'sd7, 1'b0);
    send_edge(24'sd500, -24'sd7, -24'sd37, 24'sd91, 1'b1);
    set_width(16'd1);
    send_edge(24'sd3, 24'sd4, 24'sd0, 24'sd0, 1'b1);

    // random paths, several widths
    calm_in = 1'b1; calm_out = 1'b1;      // calm stretch: no idling either side
    set_width(16'($urandom));
    for (i = 0; i < 6; i++) send_path($urandom_range(1, 8));
    calm_in = 1'b0; calm_out = 1'b0;
    hold_off_req = 1'b1;                   // long receiver stall, queue fills
    for (i = 0; i < 4; i++) send_path($urandom_range(2, 5));
    in_valid <= 1'b0;
    while (!hold_off_done) @(posedge clk);
    set_width(16'hFFFF);
    for (i = 0; i < 12; i++) send_path($urandom_range(1, 10));
    set_width(16'd0);
    for (i = 0; i < 4; i++) send_path($urandom_range(1, 6));
    set_width(16'($urandom_range(1, 400)));
    while (edges_seen < 370) send_path($urandom_range(1, 12));

    drain();
    $display("covered %0d edges, %0d result beats, widths from 0 to 65535,",
             edges_seen, beats_seen);
    $display("closed paths, degenerate edges, coordinate extremes, long output stall");
    if (mismatches == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/psqg_pkg.sv
rtl/psqg_fifo.sv
rtl/psqg_front.sv
rtl/psqg_isqrt.sv
rtl/psqg_back.sv
rtl/polyline_stroke_quad_generator.sv
verif/polyline_stroke_quad_checker.sv
verif/polyline_stroke_quad_generator_tb.sv
